[hdl/tnrc_pkg.sv]
// Shared types, constants and helpers of the tick and nanosecond ratio converter.
package tnrc_pkg;

  localparam int unsigned ValW    = 64;
  localparam int unsigned RatioW  = 32;
  localparam int unsigned CfgIdxW = 2;
  // One quotient bit is settled in each divider cell.
  localparam int unsigned NumCells = ValW;

  localparam logic [CfgIdxW-1:0] CFG_NUMERATOR   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DENOMINATOR = 2'd1;

  localparam logic MODE_TICKS_TO_NS = 1'b0;
  localparam logic MODE_NS_TO_TICKS = 1'b1;

  // Flow control seen by one pipeline stage: the global advance and the
  // occupancy of the stage that follows it.
  typedef struct packed {
    logic adv;
    logic nxt_valid;
  } tnrc_flow_t;

  // Beat carried along the divider chain.
  typedef struct packed {
    logic              neg;
    logic [RatioW-1:0] divisor;
    logic [RatioW-1:0] rem;
    logic [ValW-1:0]   quo;
  } tnrc_div_t;

  // Occupancy of a stage after this edge: it takes the upstream beat when it
  // loads, empties when its own beat moves on, and otherwise holds.
  function automatic logic stage_valid(logic load, logic drain, logic in_valid,
                                       logic cur_valid);
    logic nxt;
    if (load) begin
      nxt = in_valid;
    end else if (drain) begin
      nxt = 1'b0;
    end else begin
      nxt = cur_valid;
    end
    return nxt;
  endfunction

endpackage

[hdl/tnrc_front.sv]
// Front stages: ratio multiply in partial products, product assembly and sign removal.
module tnrc_front import tnrc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tnrc_flow_t        flow_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic [ValW-1:0]   value_in_i,
  input  logic [RatioW-1:0] ratio_numerator_i,
  input  logic [RatioW-1:0] ratio_denominator_i,
  output logic              valid_o,
  output tnrc_div_t         data_o
);

  localparam int unsigned HalfW = ValW / 2;

  logic              v1_q, v2_q, v3_q;
  logic              load1, drain1, load2, drain2, load3, drain3;

  logic [ValW-1:0]   plo_q, plo_d;
  logic [HalfW-1:0]  phi_q, phi_d;
  logic              mode1_q;
  logic [RatioW-1:0] div1_q, div1_d;

  logic [ValW-1:0]   sum_q, sum_d;
  logic              mode2_q;
  logic [RatioW-1:0] div2_q;

  tnrc_div_t         dat3_q, dat3_d;

  logic [RatioW-1:0] mult;
  logic              neg2;

  assign load1  = flow_i.adv || !v1_q;
  assign drain1 = flow_i.adv || !v2_q;
  assign load2  = flow_i.adv || !v2_q;
  assign drain2 = flow_i.adv || !v3_q;
  assign load3  = flow_i.adv || !v3_q;
  assign drain3 = flow_i.adv || !flow_i.nxt_valid;

  assign in_ready_o = load1;

  always_comb begin
    if (mode_i == MODE_NS_TO_TICKS) begin
      mult   = ratio_denominator_i;
      div1_d = ratio_numerator_i;
    end else begin
      mult   = ratio_numerator_i;
      div1_d = ratio_denominator_i;
    end
    // A zero divisor behaves as one, so the quotient is the product itself.
    if (div1_d == '0) begin
      div1_d = RatioW'(1);
    end
    // Only the low half of the upper partial product survives the wrap.
    plo_d = ValW'(value_in_i[HalfW-1:0]) * ValW'(mult);
    phi_d = value_in_i[ValW-1:HalfW] * HalfW'(mult);
  end

  assign sum_d = plo_q + {phi_q, {HalfW{1'b0}}};
  assign neg2  = (mode2_q == MODE_NS_TO_TICKS) && sum_q[ValW-1];

  always_comb begin
    dat3_d.neg     = neg2;
    dat3_d.divisor = div2_q;
    dat3_d.rem     = '0;
    dat3_d.quo     = neg2 ? (~sum_q + ValW'(1)) : sum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= stage_valid(load1, drain1, in_valid_i, v1_q);
      v2_q <= stage_valid(load2, drain2, v1_q, v2_q);
      v3_q <= stage_valid(load3, drain3, v2_q, v3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load1) begin
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      mode1_q <= mode_i;
      div1_q  <= div1_d;
    end
    if (load2) begin
      sum_q   <= sum_d;
      mode2_q <= mode1_q;
      div2_q  <= div1_q;
    end
    if (load3) begin
      dat3_q <= dat3_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = dat3_q;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted beat did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !flow_i.adv && v2_q |=> v1_q && $stable(plo_q) && $stable(div1_q))
    else $error("stalled first stage lost its beat");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> div1_q != '0)
    else $error("zero divisor reached the pipeline");

endmodule

[hdl/tnrc_div_cell.sv]
// One cell of the restoring divider chain, settling a single quotient bit.
module tnrc_div_cell import tnrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tnrc_flow_t flow_i,
  input  logic       valid_i,
  input  tnrc_div_t  data_i,
  output logic       valid_o,
  output tnrc_div_t  data_o
);

  logic          valid_q;
  tnrc_div_t     data_q, data_d;
  logic          load, drain;
  logic [RatioW:0]   trial;
  logic [RatioW+1:0] diff;
  logic          fits;

  assign load  = flow_i.adv || !valid_q;
  assign drain = flow_i.adv || !flow_i.nxt_valid;

  // Bring down the next dividend bit and subtract the divisor if it fits.
  assign trial = {data_i.rem, data_i.quo[ValW-1]};
  assign diff  = {1'b0, trial} - {2'b00, data_i.divisor};
  assign fits  = !diff[RatioW+1];

  always_comb begin
    data_d         = data_i;
    data_d.rem     = fits ? diff[RatioW-1:0] : trial[RatioW-1:0];
    data_d.quo     = {data_i.quo[ValW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_valid(load, drain, valid_i, valid_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> data_q.rem < data_q.divisor)
    else $error("partial remainder not below divisor");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !load && flow_i.nxt_valid |=> valid_q && $stable(data_q))
    else $error("stalled divider cell lost its beat");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !flow_i.adv && flow_i.nxt_valid |-> !load)
    else $error("divider cell would overwrite a held beat");

endmodule

[hdl/tick_nanosecond_ratio_converter.sv]
// Top level of the tick and nanosecond ratio converter.
// Converts 64-bit timestamps by the ratio numerator/denominator: in mode 0 the
// unsigned tick value is multiplied by the numerator (wrapping at 64 bits) and
// divided by the denominator; in mode 1 the signed nanosecond value is
// multiplied by the denominator and divided by the numerator, truncating
// toward zero. A divisor register holding zero acts as one. One beat is taken
// in every cycle when the output is not stalled, and each beat passes through
// 68 registers in a row, namely three front stages (two 32 by 32 partial
// products, product assembly, sign removal), a chain of 64 divider cells that
// each settle one quotient bit, and the output register that restores the
// sign. Empty stages close up while the output is stalled, so input beats are
// still taken until the chain is full. Ratio registers reset to one and must
// only be written while the converter holds no beat.
module tick_nanosecond_ratio_converter import tnrc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [RatioW-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [ValW-1:0]    value_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ValW-1:0]    value_out_o
);

  logic [RatioW-1:0] num_q, den_q;
  logic              adv;
  logic              out_valid_q;
  logic [ValW-1:0]   value_out_q, value_out_d;

  logic              front_valid;
  tnrc_div_t         front_data;
  tnrc_flow_t        front_flow;

  logic              cell_valid [NumCells];
  tnrc_div_t         cell_data  [NumCells];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= RatioW'(1);
      den_q <= RatioW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NUMERATOR:   num_q <= cfg_wdata_i;
        CFG_DENOMINATOR: den_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves on together whenever the output can take a beat.
  assign adv = out_ready_i || !out_valid_q;

  assign front_flow.adv       = adv;
  assign front_flow.nxt_valid = cell_valid[0];

  tnrc_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .flow_i              (front_flow),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .mode_i              (mode_i),
    .value_in_i          (value_in_i),
    .ratio_numerator_i   (num_q),
    .ratio_denominator_i (den_q),
    .valid_o             (front_valid),
    .data_o              (front_data)
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    tnrc_flow_t flow;
    logic       vin;
    tnrc_div_t  din;

    assign flow.adv = adv;
    if (k == NumCells - 1) begin : g_last
      assign flow.nxt_valid = out_valid_q;
    end else begin : g_mid
      assign flow.nxt_valid = cell_valid[k+1];
    end
    if (k == 0) begin : g_first
      assign vin = front_valid;
      assign din = front_data;
    end else begin : g_chain
      assign vin = cell_valid[k-1];
      assign din = cell_data[k-1];
    end

    tnrc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .flow_i  (flow),
      .valid_i (vin),
      .data_i  (din),
      .valid_o (cell_valid[k]),
      .data_o  (cell_data[k])
    );
  end

  assign value_out_d = cell_data[NumCells-1].neg ?
                       (~cell_data[NumCells-1].quo + ValW'(1)) :
                       cell_data[NumCells-1].quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= cell_valid[NumCells-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      value_out_q <= value_out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = value_out_q;

endmodule
